// ===== rtl/timestamped_position_history_interp_assert.svh =====
// Assertion macros shared by the position history RTL.
`ifndef TIMESTAMPED_POSITION_HISTORY_INTERP_ASSERT_SVH
`define TIMESTAMPED_POSITION_HISTORY_INTERP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPHI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tphi assertion failed");

// Next-cycle implication, checked outside reset.
`define TPHI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tphi assertion failed");

`endif

// ===== rtl/tphi_pkg.sv =====
// Types and codes of the position history block.
package tphi_pkg;

    typedef enum logic [2:0] {
        FUNC_ADD    = 3'd0,
        FUNC_QUERY  = 3'd1,
        FUNC_PRUNE  = 3'd2,
        FUNC_LATEST = 3'd3,
        FUNC_CLEAR  = 3'd4
    } t_func;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [31:0] t;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_CLR,
        S_PR_RD,
        S_PR_CHK,
        S_LT_RD,
        S_LT_CAP,
        S_QN_RD,
        S_QN_CHK,
        S_QO_CHK,
        S_QS_CHK,
        S_BR,
        S_DIF,
        S_MUL,
        S_DVW,
        S_FIN
    } t_state;

    localparam logic [31:0] MAX_AGE_RESET = 32'd1000;

endpackage

// ===== rtl/tphi_hist.sv =====
// Snapshot ring storage: one write port, one registered read port.
module tphi_hist #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  tphi_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output tphi_pkg::t_entry  o_rdata
);

    tphi_pkg::t_entry r_mem [DEPTH];
    tphi_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tphi_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module tphi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [32:0] o_quot,
    output logic        o_rem_nz
);

    logic [63:0] r_dvd;
    logic [32:0] r_quot;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [32:0] w_trial;
    logic        w_ge;

    // one trial subtract per cycle
    assign w_trial = {r_rem, r_dvd[63]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 7'd64;
            end else if (r_run) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath; the quotient never exceeds 33 bits here
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dvs  <= i_divisor;
            r_rem  <= 32'd0;
            r_quot <= 33'd0;
        end else if (r_run) begin
            r_dvd  <= {r_dvd[62:0], 1'b0};
            r_quot <= {r_quot[31:0], w_ge};
            r_rem  <= w_ge ? 32'(w_trial - {1'b0, r_dvs}) : w_trial[31:0];
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_quot;
    assign o_rem_nz = (r_rem != 32'd0);

endmodule

// ===== rtl/timestamped_position_history_interp.sv =====
// Top level: snapshot ring with add, query, prune, latest and clear sequencer.
//
//  channel | ports                                            | transfer
//  --------+--------------------------------------------------+--------------------------
//  command | i_start o_busy i_func i_pos_x i_pos_y i_time_ms  | i_start & !o_busy
//  result  | o_done o_found o_out_x o_out_y o_out_time        | o_done, one cycle
//  config  | i_cfg_valid o_cfg_ready i_cfg_data               | i_cfg_valid & o_cfg_ready
//
// Add and clear update the ring; unused codes do nothing; latest reads the newest.
// Prune drops oldest snapshots while they are too old. Query returns the newest at or
// after it, the oldest at or before it, else scans pairs: a zero span gives the older
// point, else two interpolations follow (setup, multiply, wait on the shared divider).
// Empty ring: prune, latest and query finish directly. Results cannot be held off.
// Reset is synchronous, active low; stored snapshots are not cleared.
`include "timestamped_position_history_interp_assert.svh"

module timestamped_position_history_interp #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [31:0]        i_time_ms,
    output logic               o_done,
    output logic               o_found,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic [31:0]        o_out_time,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tphi_pkg::t_state r_state, n_state;
    logic [2:0]        r_func;
    logic signed [31:0] r_px, r_py;
    logic [31:0]       r_t;
    logic [31:0]       r_max_age;
    logic [AW-1:0]     r_oldest;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_scan;
    logic [CW-1:0]     r_idx;
    tphi_pkg::t_entry  r_a, r_b;
    logic [31:0]       r_num, r_span;
    logic              r_coord;
    logic [32:0]       r_mag;
    logic              r_neg;
    logic signed [31:0] r_base;
    logic              r_found;
    logic signed [31:0] r_ox, r_oy;
    logic [31:0]       r_ot;

    tphi_pkg::t_entry  w_rdata, w_wdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [AW-1:0]     w_newest, w_next_old, w_next_scan;
    logic              w_div_start, w_div_done, w_rem_nz;
    logic [32:0]       w_quot;
    logic [63:0]       w_prod;
    logic              w_age_old, w_bracket, w_last;
    logic signed [32:0] w_diff;
    logic signed [34:0] w_fl;

    // slot index (a + b) mod DEPTH, a < DEPTH and b <= DEPTH
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign w_newest    = slot_add(r_oldest, r_count - CW'(1));
    assign w_next_old  = slot_add(r_oldest, CW'(1));
    assign w_next_scan = slot_add(r_scan, CW'(1));
    assign w_age_old   = (32'(r_t - w_rdata.t) > r_max_age);
    assign w_bracket   = (r_t >= r_a.t) && (r_t <= w_rdata.t);
    assign w_last      = ((r_idx + CW'(1)) == r_count);

    // |diff| * num, loaded by the divider in the cycle it starts
    assign w_prod      = 64'(r_mag * r_num);

    // storage and shared divider
    tphi_hist #(.DEPTH(DEPTH), .AW(AW)) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tphi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem_nz   (w_rem_nz)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tphi_pkg::S_IDLE: begin
                if (i_start) begin
                    priority case (i_func)
                        tphi_pkg::FUNC_ADD:    n_state = tphi_pkg::S_ADD;
                        tphi_pkg::FUNC_QUERY:  n_state = tphi_pkg::S_QN_RD;
                        tphi_pkg::FUNC_PRUNE:  n_state = tphi_pkg::S_PR_RD;
                        tphi_pkg::FUNC_LATEST: n_state = tphi_pkg::S_LT_RD;
                        tphi_pkg::FUNC_CLEAR:  n_state = tphi_pkg::S_CLR;
                        default:               n_state = tphi_pkg::S_FIN;
                    endcase
                end
            end
            tphi_pkg::S_ADD, tphi_pkg::S_CLR: n_state = tphi_pkg::S_FIN;
            tphi_pkg::S_PR_RD:
                n_state = (r_count == '0) ? tphi_pkg::S_FIN : tphi_pkg::S_PR_CHK;
            tphi_pkg::S_PR_CHK:
                n_state = w_age_old ? tphi_pkg::S_PR_RD : tphi_pkg::S_FIN;
            tphi_pkg::S_LT_RD:
                n_state = (r_count == '0) ? tphi_pkg::S_FIN : tphi_pkg::S_LT_CAP;
            tphi_pkg::S_LT_CAP: n_state = tphi_pkg::S_FIN;
            tphi_pkg::S_QN_RD:
                n_state = (r_count == '0) ? tphi_pkg::S_FIN : tphi_pkg::S_QN_CHK;
            tphi_pkg::S_QN_CHK:
                n_state = (r_t >= w_rdata.t) ? tphi_pkg::S_FIN : tphi_pkg::S_QO_CHK;
            tphi_pkg::S_QO_CHK:
                n_state = (r_t <= w_rdata.t) ? tphi_pkg::S_FIN : tphi_pkg::S_QS_CHK;
            tphi_pkg::S_QS_CHK: begin
                if (w_bracket) n_state = tphi_pkg::S_BR;
                else if (w_last) n_state = tphi_pkg::S_FIN;
            end
            tphi_pkg::S_BR:
                n_state = (r_b.t == r_a.t) ? tphi_pkg::S_FIN : tphi_pkg::S_DIF;
            tphi_pkg::S_DIF: n_state = tphi_pkg::S_MUL;
            tphi_pkg::S_MUL: n_state = tphi_pkg::S_DVW;
            tphi_pkg::S_DVW: begin
                if (w_div_done) n_state = r_coord ? tphi_pkg::S_FIN : tphi_pkg::S_DIF;
            end
            tphi_pkg::S_FIN: n_state = tphi_pkg::S_IDLE;
            default: n_state = tphi_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_we        = 1'b0;
        w_waddr     = slot_add(r_oldest, r_count);
        w_wdata     = '{x: r_px, y: r_py, t: r_t};
        w_raddr     = r_oldest;
        w_div_start = 1'b0;
        unique case (r_state)
            tphi_pkg::S_ADD:   w_we = 1'b1;
            tphi_pkg::S_LT_RD, tphi_pkg::S_QN_RD: w_raddr = w_newest;
            tphi_pkg::S_QN_CHK: w_raddr = r_oldest;
            tphi_pkg::S_QO_CHK: w_raddr = w_next_old;
            tphi_pkg::S_QS_CHK: w_raddr = w_next_scan;
            tphi_pkg::S_MUL:   w_div_start = 1'b1;
            default: ;
        endcase
    end

    // sign-corrected truncation of a + sign * q
    always_comb begin
        w_diff = 33'sd0;
        if (r_coord) w_diff = 33'(r_b.y) - 33'(r_a.y);
        else         w_diff = 33'(r_b.x) - 33'(r_a.x);
        if (!r_neg) begin
            w_fl = 35'(r_base) + $signed({2'b00, w_quot});
        end else begin
            w_fl = 35'(r_base) - $signed({2'b00, w_quot}) - 35'(w_rem_nz);
        end
        if (w_fl < 0 && w_rem_nz) begin
            w_fl = w_fl + 35'sd1;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tphi_pkg::S_IDLE;
            r_max_age <= tphi_pkg::MAX_AGE_RESET;
            r_oldest  <= '0;
            r_count   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_max_age <= i_cfg_data;
            end
            unique case (r_state)
                tphi_pkg::S_ADD: begin
                    if (r_count >= CW'(DEPTH)) r_oldest <= w_next_old;
                    else r_count <= r_count + CW'(1);
                end
                tphi_pkg::S_CLR: begin
                    r_count  <= '0;
                    r_oldest <= '0;
                end
                tphi_pkg::S_PR_CHK: begin
                    if (w_age_old) begin
                        r_oldest <= w_next_old;
                        r_count  <= r_count - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tphi_pkg::S_IDLE: begin
                if (i_start) begin
                    r_func  <= i_func;
                    r_px    <= i_pos_x;
                    r_py    <= i_pos_y;
                    r_t     <= i_time_ms;
                    r_found <= 1'b0;
                    r_ox    <= 32'sd0;
                    r_oy    <= 32'sd0;
                    r_ot    <= 32'd0;
                end
            end
            tphi_pkg::S_LT_CAP: begin
                r_found <= 1'b1;
                r_ox    <= w_rdata.x;
                r_oy    <= w_rdata.y;
                r_ot    <= w_rdata.t;
            end
            tphi_pkg::S_QN_CHK, tphi_pkg::S_QO_CHK: begin
                if (((r_state == tphi_pkg::S_QN_CHK) && (r_t >= w_rdata.t)) ||
                    ((r_state == tphi_pkg::S_QO_CHK) && (r_t <= w_rdata.t))) begin
                    r_found <= 1'b1;
                    r_ox    <= w_rdata.x;
                    r_oy    <= w_rdata.y;
                end
                r_a    <= w_rdata;
                r_scan <= w_next_old;
                r_idx  <= CW'(1);
            end
            tphi_pkg::S_QS_CHK: begin
                if (w_bracket) begin
                    r_b <= w_rdata;
                end else begin
                    r_a    <= w_rdata;
                    r_scan <= w_next_scan;
                    r_idx  <= r_idx + CW'(1);
                end
            end
            tphi_pkg::S_BR: begin
                r_found <= 1'b1;
                r_span  <= r_b.t - r_a.t;
                r_num   <= r_t - r_a.t;
                r_coord <= 1'b0;
                if (r_b.t == r_a.t) begin
                    r_ox <= r_a.x;
                    r_oy <= r_a.y;
                end
            end
            tphi_pkg::S_DIF: begin
                r_neg  <= w_diff[32];
                r_mag  <= w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
                r_base <= r_coord ? r_a.y : r_a.x;
            end
            tphi_pkg::S_DVW: begin
                if (w_div_done) begin
                    if (r_coord) r_oy <= w_fl[31:0];
                    else r_ox <= w_fl[31:0];
                    r_coord <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_busy      = (r_state != tphi_pkg::S_IDLE);
    assign o_done      = (r_state == tphi_pkg::S_FIN);
    assign o_found     = r_found;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_time  = r_ot;
    assign o_cfg_ready = 1'b1;

    // checks
    `TPHI_ASSERT_IMP(a_div_in_wait, i_clk, i_rst_n, w_div_done,
        r_state == tphi_pkg::S_DVW)
    `TPHI_ASSERT_NXT(a_full_add_keeps, i_clk, i_rst_n,
        (r_state == tphi_pkg::S_ADD) && (r_count == CW'(DEPTH)), r_count == CW'(DEPTH))
    `TPHI_ASSERT_IMP(a_no_pos_result, i_clk, i_rst_n,
        o_done && (r_func != tphi_pkg::FUNC_QUERY) && (r_func != tphi_pkg::FUNC_LATEST),
        !o_found && (o_out_x == 32'sd0) && (o_out_time == 32'd0))
    `TPHI_ASSERT_NXT(a_done_to_idle, i_clk, i_rst_n, o_done, !o_busy && !o_done)

endmodule
